FILE: design/superio_config_unlock_regs_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the super I/O configuration unlock unit
// Property shorthands clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SUPERIO_CONFIG_UNLOCK_REGS_UNIT_MACROS_SVH
`define SUPERIO_CONFIG_UNLOCK_REGS_UNIT_MACROS_SVH

// Same-cycle implication.
`define SIO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SIO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/sio_unlk_pkg.sv
// ----------------------------------------------------------------------------
// sio_unlk_pkg
// Shared types and constants for the super I/O configuration unlock unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sio_unlk_pkg;

  localparam int unsigned NREGS = 15;

  localparam logic [15:0] ADDR_CTL_A = 16'h02fa;
  localparam logic [15:0] ADDR_CTL_B = 16'h03fa;
  localparam logic [7:0]  UNLOCK_KEY = 8'h36;
  localparam logic [7:0]  CHECK_SUM  = 8'hff;
  localparam logic [7:0]  READ_IDLE  = 8'hff;
  localparam logic [3:0]  IDX_EXIT   = 4'hf;
  localparam logic [3:0]  IDX_RES    = 4'h0;
  localparam logic [3:0]  IDX_UART   = 4'h4;
  localparam logic [3:0]  IDX_PRN    = 4'h6;

  // Register 4 values giving a UART base of 0x3f8 and 0x2f8.
  localparam logic [7:0]  UART_PRI   = 8'hfe;
  localparam logic [7:0]  UART_SEC   = 8'hbe;

  // Reset contents of the setting registers, index 0 in the lowest byte.
  localparam logic [NREGS-1:0][7:0] REG_INIT = {
    8'h00, 8'h00, 8'ha0, 8'h00, 8'h00, 8'hb0, 8'h00, 8'h00,
    8'h9e, 8'h00, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h0c
  };

  typedef enum logic {
    REQ_READ  = 1'b0,
    REQ_WRITE = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t   req_type;
    logic [15:0] io_address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        config_active;
    logic        resource_update;
    logic        uart_valid;
    logic        uart_channel;
    logic [9:0]  uart_base;
    logic        printer_valid;
    logic [9:0]  printer_base;
  } result_t;

endpackage

`default_nettype wire

FILE: design/superio_config_unlock_regs_unit.sv
// ----------------------------------------------------------------------------
// superio_config_unlock_regs_unit
// Super I/O configuration unlock sequence and setting register file.
// ----------------------------------------------------------------------------
// Each word on the slave side is one I/O bus access and yields exactly one
// result word on the master side. The unit sustains one word per clock while
// the master side is ready: a word is held in the input register, where the
// unlock sequencer and the register file update their state, and the result
// leaves from the output register. The single state update per cycle in the
// core sets this rate. There is no clearing pass after reset; the unit takes
// words from the first cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "superio_config_unlock_regs_unit_macros.svh"

module superio_config_unlock_regs_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // io_address[15:0], write_data[23:16]
  input  wire logic        s_tuser,   // req_type (0 read, 1 write)
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // read_data[7:0], config_active[8],
                                      // uart_valid[9], uart_channel[10],
                                      // uart_base[20:11], printer_valid[21],
                                      // printer_base[31:22]
  output logic             m_tuser    // resource_update
);
  import sio_unlk_pkg::*;

  logic     in_valid;
  in_item_t in_item;
  logic     out_valid;
  result_t  out_res;
  result_t  core_res;
  logic     take;

  assign take     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || take;

  sio_unlk_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (take),
    .item (in_item),
    .res  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.req_type   <= req_kind_t'(s_tuser);
      in_item.io_address <= s_tdata[15:0];
      in_item.write_data <= s_tdata[23:16];
    end
    if (take) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_res.resource_update;
  assign m_tdata  = {out_res.printer_base, out_res.printer_valid, out_res.uart_base,
                     out_res.uart_channel, out_res.uart_valid, out_res.config_active,
                     out_res.read_data};

  `SIO_ASSERT_NEXT(a_accept_loads, s_tvalid && s_tready, in_valid, "accepted word not held")
  `SIO_ASSERT_NOW(a_upd_is_write, m_tvalid && m_tuser, m_tdata[7:0] == READ_IDLE, "update on a read")
  `SIO_ASSERT_NOW(a_upd_in_cfg, m_tvalid && m_tuser, m_tdata[8], "update outside config mode")
  `SIO_ASSERT_NOW(a_chan_valid, m_tvalid && m_tdata[10], m_tdata[9], "UART channel without valid")

endmodule

`default_nettype wire

FILE: design/sio_unlk_core.sv
// ----------------------------------------------------------------------------
// sio_unlk_core
// Unlock sequencer, index/data port decode and setting register file.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sio_unlk_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  fire,
  input  wire sio_unlk_pkg::in_item_t item,
  output sio_unlk_pkg::result_t      res
);
  import sio_unlk_pkg::*;

  typedef enum logic [2:0] {
    ST_WAIT_KEY   = 3'd0,
    ST_WAIT_CPL   = 3'd1,
    ST_WAIT_MAGIC = 3'd2,
    ST_WAIT_BASE  = 3'd3,
    ST_WAIT_CHECK = 3'd4
  } step_t;

  step_t                   step, step_next;
  logic [7:0]              expect_cpl, expect_cpl_next;
  logic [7:0]              base_byte, base_byte_next;
  logic                    cfg_mode, cfg_mode_next;
  logic [3:0]              sel_idx, sel_idx_next;
  logic [NREGS-1:0][7:0]   regs;

  logic       is_write;
  logic       hit_a, hit_b, ctl_port, advance;
  logic       mode_mid;
  logic       hit_idx_old, hit_dat_old, hit_idx, hit_dat;
  logic       reg_we, upd;
  logic [7:0] rd;
  logic [7:0] val;
  logic [7:0] sum;

  always_comb begin
    is_write = (item.req_type == REQ_WRITE);
    val      = item.write_data;
    hit_a    = (item.io_address == ADDR_CTL_A);
    hit_b    = (item.io_address == ADDR_CTL_B);
    ctl_port = hit_a || hit_b;
    sum      = base_byte + val;

    hit_idx_old = (item.io_address == {6'd0, base_byte, 2'b00});
    hit_dat_old = (item.io_address == {6'd0, base_byte, 2'b01});

    // Read path works on the state as it stands.
    rd = READ_IDLE;
    if (!is_write && cfg_mode) begin
      if (hit_idx_old) begin
        rd = {4'd0, sel_idx};
      end else if (hit_dat_old) begin
        rd = (sel_idx == IDX_EXIT) ? base_byte : regs[sel_idx];
      end
    end

    expect_cpl_next = expect_cpl;
    base_byte_next  = base_byte;
    mode_mid        = cfg_mode;
    advance         = 1'b0;
    if (is_write && hit_a) begin
      if (step == ST_WAIT_KEY) begin
        advance         = 1'b1;
        expect_cpl_next = ~val;
      end else if (step == ST_WAIT_CHECK) begin
        mode_mid = (sum == CHECK_SUM);
      end
    end else if (is_write && hit_b) begin
      if (step == ST_WAIT_CPL && val == expect_cpl) begin
        advance = 1'b1;
      end else if (step == ST_WAIT_MAGIC && val == UNLOCK_KEY) begin
        advance = 1'b1;
      end else if (step == ST_WAIT_BASE) begin
        base_byte_next = val;
        advance        = 1'b1;
      end
    end

    // Port decode for writes follows a base byte written by this same word.
    hit_idx = (item.io_address == {6'd0, base_byte_next, 2'b00});
    hit_dat = (item.io_address == {6'd0, base_byte_next, 2'b01});

    cfg_mode_next = mode_mid;
    sel_idx_next  = sel_idx;
    reg_we        = 1'b0;
    upd           = 1'b0;
    if (is_write && mode_mid) begin
      if (hit_idx) begin
        sel_idx_next = val[3:0];
      end else if (hit_dat) begin
        if (sel_idx == IDX_EXIT) begin
          cfg_mode_next = 1'b0;
        end else begin
          reg_we = 1'b1;
          upd    = (sel_idx == IDX_RES);
        end
      end
    end

    step_next = step;
    if (is_write && ctl_port) begin
      step_next = ST_WAIT_KEY;
      if (advance) begin
        unique case (step)
          ST_WAIT_KEY:   step_next = ST_WAIT_CPL;
          ST_WAIT_CPL:   step_next = ST_WAIT_MAGIC;
          ST_WAIT_MAGIC: step_next = ST_WAIT_BASE;
          ST_WAIT_BASE:  step_next = ST_WAIT_CHECK;
          default:       step_next = ST_WAIT_KEY;
        endcase
      end
    end else if (is_write && cfg_mode && (hit_idx || hit_dat)) begin
      step_next = ST_WAIT_KEY;
    end

    // Resource report; the word just written is the new register 0.
    res                 = '0;
    res.read_data       = rd;
    res.config_active   = is_write ? cfg_mode_next : cfg_mode;
    res.resource_update = upd;
    if (upd) begin
      res.uart_valid    = val[2] && (regs[IDX_UART] == UART_PRI ||
                                     regs[IDX_UART] == UART_SEC);
      res.uart_channel  = val[2] && (regs[IDX_UART] == UART_SEC);
      res.uart_base     = {regs[IDX_UART], 2'b00};
      res.printer_valid = val[3];
      res.printer_base  = {regs[IDX_PRN], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= ST_WAIT_KEY;
      expect_cpl <= '0;
      base_byte  <= '0;
      cfg_mode   <= 1'b0;
      sel_idx    <= '0;
      regs       <= REG_INIT;
    end else if (fire) begin
      step       <= step_next;
      expect_cpl <= expect_cpl_next;
      base_byte  <= base_byte_next;
      cfg_mode   <= cfg_mode_next;
      sel_idx    <= sel_idx_next;
      if (reg_we) begin
        regs[sel_idx] <= val;
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/superio_config_unlock_regs_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the super I/O configuration unlock unit
// Drives I/O bus read and write words with random gaps and back-pressure and
// compares every result word against an in-bench model of the unlock sequence
// and the setting register file.
// ----------------------------------------------------------------------------
module superio_config_unlock_regs_unit_test;
  import sio_unlk_pkg::*;

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          ITEM_TARGET = 750;
  localparam logic [9:0]  UART_AT_PRI = 10'h3f8;
  localparam logic [9:0]  UART_AT_SEC = 10'h2f8;

  // Tracks the unlock sequence and register file, and holds the results that
  // accepted accesses still owe.
  class superio_scoreboard;
    logic [2:0] seq_step;
    logic [7:0] want_compl;
    logic [7:0] base_byte;
    bit         cfg_on;
    logic [3:0] sel;
    logic [7:0] regs [NREGS];
    result_t    due_results [$];
    int         errors;

    function new();
      int i;
      seq_step   = '0;
      want_compl = '0;
      base_byte  = '0;
      cfg_on     = 1'b0;
      sel        = '0;
      errors     = 0;
      for (i = 0; i < NREGS; i++) regs[i] = REG_INIT[i];
    endfunction

    function void apply_bus_access(in_item_t acc);
      result_t     res;
      logic [15:0] idx_port;
      logic [15:0] dat_port;
      logic [9:0]  uart_at;
      bit          advance;
      bit          ctl_port;
      bit          was_on;
      bit          upd;
      res           = '0;
      res.read_data = READ_IDLE;
      idx_port      = {6'b0, base_byte, 2'b00};
      dat_port      = idx_port + 16'd1;
      upd           = 1'b0;
      if (acc.req_type == REQ_READ) begin
        if (cfg_on) begin
          if (acc.io_address == idx_port) begin
            res.read_data = {4'b0, sel};
          end else if (acc.io_address == dat_port) begin
            if (sel == IDX_EXIT) res.read_data = base_byte;
            else res.read_data = regs[sel];
          end
        end
      end else begin
        advance  = 1'b0;
        ctl_port = (acc.io_address == ADDR_CTL_A) || (acc.io_address == ADDR_CTL_B);
        was_on   = cfg_on;
        if (acc.io_address == ADDR_CTL_A) begin
          if (seq_step == 3'd0) begin
            advance    = 1'b1;
            want_compl = CHECK_SUM - acc.write_data;
          end else if (seq_step == 3'd4) begin
            cfg_on = ((base_byte + acc.write_data) == CHECK_SUM);
          end
        end else if (acc.io_address == ADDR_CTL_B) begin
          if (seq_step == 3'd1 && acc.write_data == want_compl) begin
            advance = 1'b1;
          end else if (seq_step == 3'd2 && acc.write_data == UNLOCK_KEY) begin
            advance = 1'b1;
          end else if (seq_step == 3'd3) begin
            base_byte = acc.write_data;
            advance   = 1'b1;
          end
        end
        // The base byte may just have moved, so the ports are decoded afresh.
        idx_port = {6'b0, base_byte, 2'b00};
        dat_port = idx_port + 16'd1;
        if (cfg_on) begin
          if (acc.io_address == idx_port) begin
            sel = acc.write_data[3:0];
          end else if (acc.io_address == dat_port) begin
            if (sel == IDX_EXIT) begin
              cfg_on = 1'b0;
            end else begin
              regs[sel] = acc.write_data;
              upd = (sel == IDX_RES);
            end
          end
        end
        if (ctl_port) begin
          seq_step = advance ? seq_step + 3'd1 : 3'd0;
        end else if (was_on && (acc.io_address == idx_port || acc.io_address == dat_port)) begin
          seq_step = 3'd0;
        end
        if (upd) begin
          uart_at             = {regs[IDX_UART], 2'b00};
          res.resource_update = 1'b1;
          res.uart_valid      = regs[IDX_RES][2] &&
                                (uart_at == UART_AT_PRI || uart_at == UART_AT_SEC);
          res.uart_channel    = regs[IDX_RES][2] && (uart_at == UART_AT_SEC);
          res.uart_base       = uart_at;
          res.printer_valid   = regs[IDX_RES][3];
          res.printer_base    = {regs[IDX_PRN], 2'b00};
        end
      end
      res.config_active = cfg_on;
      due_results.push_back(res);
    endfunction

    task report(string what, logic [15:0] got, logic [15:0] want);
      $display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report(name, got, want);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_results.size() == 0) begin
        report("result word with no access pending", 16'(got.read_data), 16'd0);
        return;
      end
      want = due_results.pop_front();
      compare_field("read_data", 16'(got.read_data), 16'(want.read_data));
      compare_field("config_active", 16'(got.config_active), 16'(want.config_active));
      compare_field("resource_update", 16'(got.resource_update),
                    16'(want.resource_update));
      compare_field("uart_valid", 16'(got.uart_valid), 16'(want.uart_valid));
      compare_field("uart_channel", 16'(got.uart_channel), 16'(want.uart_channel));
      compare_field("uart_base", 16'(got.uart_base), 16'(want.uart_base));
      compare_field("printer_valid", 16'(got.printer_valid), 16'(want.printer_valid));
      compare_field("printer_base", 16'(got.printer_base), 16'(want.printer_base));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic        m_tuser;

  superio_scoreboard sb = new();
  int                n_accepted = 0;
  int                n_taken = 0;
  int                cycles = 0;

  superio_config_unlock_regs_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result words are taken from the values present just before the edge.
  always @(posedge clk) begin : result_monitor
    result_t seen;
    if (!rst && m_tvalid && m_tready) begin
      seen.read_data       = m_tdata[7:0];
      seen.config_active   = m_tdata[8];
      seen.uart_valid      = m_tdata[9];
      seen.uart_channel    = m_tdata[10];
      seen.uart_base       = m_tdata[20:11];
      seen.printer_valid   = m_tdata[21];
      seen.printer_base    = m_tdata[31:22];
      seen.resource_update = m_tuser;
      sb.check_result(seen);
    end
  end

  initial begin : result_taker
    int gap;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      gap = (n_taken % 170 < 35) ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      n_taken++;
    end
  end

  function automatic logic [15:0] index_port();
    return {6'b0, sb.base_byte, 2'b00};
  endfunction

  function automatic logic [15:0] data_port();
    return {6'b0, sb.base_byte, 2'b01};
  endfunction

  // Valid is only lowered when a gap is drawn, so back-to-back words keep it
  // high across the edge.
  task automatic put_access(req_kind_t kind, logic [15:0] addr, logic [7:0] data);
    in_item_t acc;
    int       gap;
    gap = (n_accepted % 160 < 30) ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {data, addr};
    s_tuser  <= kind;
    do @(posedge clk); while (!s_tready);
    acc.req_type   = kind;
    acc.io_address = addr;
    acc.write_data = data;
    sb.apply_bus_access(acc);
    n_accepted++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  // The five-write unlock; a non-zero flaw spoils or disturbs one step.
  task automatic unlock_seq(logic [7:0] v, logic [7:0] b, int flaw);
    logic [7:0] flip;
    flip = 8'(1 << $urandom_range(0, 7));
    put_access(REQ_WRITE, ADDR_CTL_A, v);
    if (flaw == 5) put_access(REQ_READ, ADDR_CTL_B, 8'($urandom));
    put_access(REQ_WRITE, ADDR_CTL_B, (flaw == 1) ? ~v ^ flip : ~v);
    put_access(REQ_WRITE, ADDR_CTL_B, (flaw == 2) ? UNLOCK_KEY ^ flip : UNLOCK_KEY);
    if (flaw == 4) put_access(REQ_WRITE, index_port(), 8'($urandom));
    put_access(REQ_WRITE, ADDR_CTL_B, b);
    put_access(REQ_WRITE, ADDR_CTL_A, (flaw == 3) ? (CHECK_SUM - b) ^ flip : CHECK_SUM - b);
  endtask

  task automatic run_session(int n_acc);
    int         i;
    int         pick;
    logic [3:0] which;
    logic [7:0] d;
    if ($urandom_range(0, 1) != 0) begin
      put_access(REQ_WRITE, index_port(), {4'($urandom), IDX_UART});
      put_access(REQ_WRITE, data_port(), ($urandom_range(0, 1) != 0) ? UART_PRI : UART_SEC);
    end
    for (i = 0; i < n_acc; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1: begin
          case ($urandom_range(0, 5))
            0: which = IDX_RES;
            1: which = IDX_UART;
            2: which = IDX_PRN;
            3: which = IDX_EXIT;
            default: which = 4'($urandom);
          endcase
          put_access(REQ_WRITE, index_port(), {4'($urandom), which});
        end
        2, 3, 4: begin
          d = 8'($urandom);
          if (sb.sel == IDX_UART && $urandom_range(0, 1) != 0) begin
            d = ($urandom_range(0, 1) != 0) ? UART_PRI : UART_SEC;
          end else if (sb.sel == IDX_RES && $urandom_range(0, 2) != 0) begin
            d = d | 8'h04;
          end
          put_access(REQ_WRITE, data_port(), d);
        end
        5, 6: put_access(REQ_READ, data_port(), 8'($urandom));
        7: put_access(REQ_READ, index_port(), 8'($urandom));
        8: put_access(REQ_READ, 16'($urandom), 8'($urandom));
        default: put_access(REQ_WRITE, ($urandom_range(0, 1) != 0) ? ADDR_CTL_A : ADDR_CTL_B,
                            8'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    int pick;
    int flaw;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = REQ_READ;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Locked: nothing decodes, and the data port at the reset base ignores writes.
    put_access(REQ_READ, 16'h0000, 8'h00);
    put_access(REQ_WRITE, 16'hffff, 8'hff);
    put_access(REQ_READ, ADDR_CTL_A, 8'h00);
    put_access(REQ_WRITE, data_port(), 8'h00);
    unlock_seq(8'h00, 8'hff, 0);
    put_access(REQ_READ, index_port(), 8'hff);
    put_access(REQ_READ, data_port(), 8'h00);
    // Primary UART with both enables, then secondary UART.
    put_access(REQ_WRITE, index_port(), {4'hf, IDX_UART});
    put_access(REQ_WRITE, data_port(), UART_PRI);
    put_access(REQ_WRITE, index_port(), {4'h0, IDX_RES});
    put_access(REQ_WRITE, data_port(), 8'h0c);
    put_access(REQ_WRITE, index_port(), {4'h0, IDX_UART});
    put_access(REQ_WRITE, data_port(), UART_SEC);
    put_access(REQ_WRITE, index_port(), {4'h0, IDX_RES});
    put_access(REQ_WRITE, data_port(), 8'h04);
    // Index 15 reads back the base and a write there leaves configuration.
    put_access(REQ_WRITE, index_port(), 8'hff);
    put_access(REQ_READ, data_port(), 8'h00);
    put_access(REQ_WRITE, data_port(), 8'h00);
    // A final write with the wrong sum leaves the unit locked.
    unlock_seq(8'h5a, 8'h10, 3);
    drain_results();

    while (n_accepted < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        flaw = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
        unlock_seq(8'($urandom), 8'($urandom), flaw);
        run_session($urandom_range(2, 14));
      end else if (pick <= 7) begin
        put_access(req_kind_t'($urandom_range(0, 1)), 16'($urandom), 8'($urandom));
      end else if (pick == 8) begin
        put_access(REQ_WRITE, ($urandom_range(0, 1) != 0) ? ADDR_CTL_A : ADDR_CTL_B,
                   8'($urandom));
      end else begin
        put_access(req_kind_t'($urandom_range(0, 1)),
                   index_port() | 16'($urandom_range(0, 1)), 8'($urandom));
      end
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
